/* src/i2cms_pkg.sv */
// ============================================================================
// I2C master byte sequencer - shared package
// Command codes, item and result types used by the sequencer and its ports.
// ============================================================================
package i2cms_pkg;

    localparam int unsigned FUNC_W  = 3;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned TICKS_W = 16;
    localparam int unsigned BITS_W  = 4;

    localparam logic [TICKS_W-1:0] PHASE_TICKS_RESET = 16'd50;

    // command codes carried in func
    localparam logic [FUNC_W-1:0] FUNC_TICK  = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_START = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_STOP  = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_WRITE = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 3'd4;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [BYTE_W-1:0] tx_byte;
        logic              nack_to_send;
        logic              sda_in;
    } i2cms_item_t;

    typedef struct packed {
        logic              scl_level;
        logic              sda_release;
        logic              busy_res;
        logic              done_res;
        logic [BYTE_W-1:0] rx_byte;
        logic              nack_received;
        logic              cmd_rejected;
    } i2cms_res_t;

endpackage

/* src/i2cms_if.sv */
// ============================================================================
// I2C master byte sequencer - channel interfaces
// Valid/ready channels for tick items and for result items.
// ============================================================================
interface i2cms_cmd_if
    import i2cms_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [BYTE_W-1:0] tx_byte;
    logic              nack_to_send;
    logic              sda_in;

    modport source (output valid, func, tx_byte, nack_to_send, sda_in, input ready);
    modport sink   (input valid, func, tx_byte, nack_to_send, sda_in, output ready);
endinterface

interface i2cms_res_if
    import i2cms_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              scl_level;
    logic              sda_release;
    logic              busy_res;
    logic              done_res;
    logic [BYTE_W-1:0] rx_byte;
    logic              nack_received;
    logic              cmd_rejected;

    modport source (output valid, scl_level, sda_release, busy_res, done_res, rx_byte,
                    nack_received, cmd_rejected, input ready);
    modport sink   (input valid, scl_level, sda_release, busy_res, done_res, rx_byte,
                    nack_received, cmd_rejected, output ready);
endinterface

/* src/i2cms_core.sv */
// ============================================================================
// I2C master byte sequencer - phase engine
// Bus phase state machine; advances one tick per transfer and gives the result.
// ============================================================================
module i2cms_core
    import i2cms_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [TICKS_W-1:0] cfg_wdata,
    input  logic               take,
    input  i2cms_item_t        item,
    output i2cms_res_t         res
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'd0,
        ST_S_REL  = 5'd1,
        ST_S_SCLH = 5'd2,
        ST_S_SDAL = 5'd3,
        ST_S_SCLL = 5'd4,
        ST_P_SDAL = 5'd5,
        ST_P_SCLH = 5'd6,
        ST_P_REL  = 5'd7,
        ST_W_BIT  = 5'd8,
        ST_W_HIGH = 5'd9,
        ST_W_GAP  = 5'd10,
        ST_W_ACKH = 5'd11,
        ST_W_ACKL = 5'd12,
        ST_R_HIGH = 5'd13,
        ST_R_LOW  = 5'd14,
        ST_R_ACKD = 5'd15,
        ST_R_ACKH = 5'd16,
        ST_R_ACKL = 5'd17
    } step_t;

    step_t              step_reg,   step_next;
    logic [BITS_W-1:0]  bits_reg,   bits_next;
    logic [BYTE_W-1:0]  shift_reg,  shift_next;
    logic [TICKS_W-1:0] tick_reg,   tick_next;
    logic               ack_reg,    ack_next;
    logic               scl_reg,    scl_next;
    logic               sda_reg,    sda_next;
    logic               nack_reg,   nack_next;
    logic [BYTE_W-1:0]  rx_reg,     rx_next;
    logic [TICKS_W-1:0] phase_reg;

    logic [TICKS_W-1:0] tick_load;
    logic [TICKS_W-1:0] tick_dec;
    logic               done;
    logic               rejected;

    // a phase length of zero behaves as one
    assign tick_load = (phase_reg == '0) ? TICKS_W'(1) : phase_reg;
    assign tick_dec  = tick_reg - TICKS_W'(1);

    always_comb
    begin
        step_next  = step_reg;
        bits_next  = bits_reg;
        shift_next = shift_reg;
        tick_next  = tick_reg;
        ack_next   = ack_reg;
        scl_next   = scl_reg;
        sda_next   = sda_reg;
        nack_next  = nack_reg;
        rx_next    = rx_reg;
        done       = 1'b0;
        rejected   = 1'b0;

        if (step_reg != ST_IDLE)
        begin
            rejected  = (item.func != FUNC_TICK);
            tick_next = tick_dec;
            if (tick_dec == '0)
            begin
                tick_next = tick_load;
                unique case (step_reg)
                    ST_S_REL:
                    begin
                        step_next = ST_S_SCLH;
                        scl_next  = 1'b1;
                    end
                    ST_S_SCLH:
                    begin
                        step_next = ST_S_SDAL;
                        sda_next  = 1'b0;
                    end
                    ST_S_SDAL:
                    begin
                        step_next = ST_S_SCLL;
                        scl_next  = 1'b0;
                    end
                    ST_P_SDAL:
                    begin
                        step_next = ST_P_SCLH;
                        scl_next  = 1'b1;
                    end
                    ST_P_SCLH:
                    begin
                        step_next = ST_P_REL;
                        sda_next  = 1'b1;
                    end
                    ST_W_BIT:
                    begin
                        step_next = ST_W_HIGH;
                        scl_next  = 1'b1;
                    end
                    ST_W_HIGH:
                    begin
                        bits_next  = bits_reg + BITS_W'(1);
                        shift_next = {shift_reg[BYTE_W-2:0], 1'b0};
                        scl_next   = 1'b0;
                        if (bits_next[BITS_W-1])
                        begin
                            step_next = ST_W_GAP;
                        end
                        else
                        begin
                            step_next = ST_W_BIT;
                            sda_next  = shift_reg[BYTE_W-2];
                        end
                    end
                    ST_W_GAP:
                    begin
                        step_next = ST_W_ACKH;
                        scl_next  = 1'b1;
                        sda_next  = 1'b1;
                    end
                    ST_W_ACKH:
                    begin
                        nack_next = item.sda_in;
                        step_next = ST_W_ACKL;
                        scl_next  = 1'b0;
                    end
                    ST_R_HIGH:
                    begin
                        shift_next = {shift_reg[BYTE_W-2:0], item.sda_in};
                        bits_next  = bits_reg + BITS_W'(1);
                        step_next  = ST_R_LOW;
                        scl_next   = 1'b0;
                    end
                    ST_R_LOW:
                    begin
                        if (bits_reg[BITS_W-1])
                        begin
                            step_next = ST_R_ACKD;
                            sda_next  = ack_reg;
                        end
                        else
                        begin
                            step_next = ST_R_HIGH;
                            scl_next  = 1'b1;
                        end
                    end
                    ST_R_ACKD:
                    begin
                        step_next = ST_R_ACKH;
                        scl_next  = 1'b1;
                    end
                    ST_R_ACKH:
                    begin
                        step_next = ST_R_ACKL;
                        scl_next  = 1'b0;
                    end
                    ST_R_ACKL:
                    begin
                        rx_next   = shift_reg;
                        step_next = ST_IDLE;
                        tick_next = tick_dec;
                        done      = 1'b1;
                    end
                    default:
                    begin
                        // last phase of start, stop and write
                        step_next = ST_IDLE;
                        tick_next = tick_dec;
                        done      = 1'b1;
                    end
                endcase
            end
        end
        else
        begin
            unique case (item.func)
                FUNC_START:
                begin
                    bits_next = '0;
                    step_next = ST_S_REL;
                    sda_next  = 1'b1;
                    tick_next = tick_load;
                end
                FUNC_STOP:
                begin
                    bits_next = '0;
                    step_next = ST_P_SDAL;
                    sda_next  = 1'b0;
                    tick_next = tick_load;
                end
                FUNC_WRITE:
                begin
                    bits_next  = '0;
                    shift_next = item.tx_byte;
                    step_next  = ST_W_BIT;
                    scl_next   = 1'b0;
                    sda_next   = item.tx_byte[BYTE_W-1];
                    tick_next  = tick_load;
                end
                FUNC_READ:
                begin
                    bits_next  = '0;
                    shift_next = '0;
                    ack_next   = item.nack_to_send;
                    step_next  = ST_R_HIGH;
                    scl_next   = 1'b1;
                    sda_next   = 1'b1;
                    tick_next  = tick_load;
                end
                default:
                begin
                    // plain tick or undefined code: hold
                end
            endcase
        end
    end

    assign res.scl_level     = scl_next;
    assign res.sda_release   = sda_next;
    assign res.busy_res      = (step_next != ST_IDLE);
    assign res.done_res      = done;
    assign res.rx_byte       = rx_next;
    assign res.nack_received = nack_next;
    assign res.cmd_rejected  = rejected;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= ST_IDLE;
            bits_reg  <= '0;
            shift_reg <= '0;
            tick_reg  <= '0;
            ack_reg   <= 1'b0;
            scl_reg   <= 1'b1;
            sda_reg   <= 1'b1;
            nack_reg  <= 1'b0;
            rx_reg    <= '0;
            phase_reg <= PHASE_TICKS_RESET;
        end
        else
        begin
            if (cfg_we)
            begin
                phase_reg <= cfg_wdata;
            end
            if (take)
            begin
                step_reg  <= step_next;
                bits_reg  <= bits_next;
                shift_reg <= shift_next;
                tick_reg  <= tick_next;
                ack_reg   <= ack_next;
                scl_reg   <= scl_next;
                sda_reg   <= sda_next;
                nack_reg  <= nack_next;
                rx_reg    <= rx_next;
            end
        end
    end

endmodule

/* src/i2c_master_byte_sequencer.sv */
// Results are registered and offered on res. Each tick is a single pass through
//   the phase engine. Throughput: one tick per cycle while cmd is open; a
//   two-deep result buffer keeps cmd open for one stalled result.
// Reset (rst_n low, asynchronous): sequencer idle, SCL high, SDA released,
//   phase length 50 ticks, result buffer empty.
// ============================================================================
// I2C master byte sequencer - top level
// Plays start, stop, write-byte and read-byte commands out as timed bus phases.
// ============================================================================
module i2c_master_byte_sequencer
    import i2cms_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [TICKS_W-1:0] cfg_wdata,
    i2cms_cmd_if.sink          cmd,
    i2cms_res_if.source        res
);

    i2cms_item_t item;
    i2cms_res_t  step_res;
    logic        take;

    // main result register and its skid stage
    i2cms_res_t  main_reg;
    logic        main_valid_reg;
    i2cms_res_t  skid_reg;
    logic        skid_valid_reg;

    // Open cmd while the skid stage is free: a new tick can always be parked.
    assign cmd.ready = !skid_valid_reg;
    assign take      = cmd.valid && cmd.ready;

    assign item.func         = cmd.func;
    assign item.tx_byte      = cmd.tx_byte;
    assign item.nack_to_send = cmd.nack_to_send;
    assign item.sda_in       = cmd.sda_in;

    // The phase engine advances its state only on a transfer.
    i2cms_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .take      (take),
        .item      (item),
        .res       (step_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!main_valid_reg || res.ready)
        begin
            // main register drains or is empty: refill from skid first, keep order
            if (skid_valid_reg)
            begin
                main_valid_reg <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                main_valid_reg <= take;
            end
        end
        else if (take)
        begin
            // main is stalled: park the new result
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!main_valid_reg || res.ready)
        begin
            main_reg <= skid_valid_reg ? skid_reg : step_res;
        end
        else if (take)
        begin
            skid_reg <= step_res;
        end
    end

    assign res.valid         = main_valid_reg;
    assign res.scl_level     = main_reg.scl_level;
    assign res.sda_release   = main_reg.sda_release;
    assign res.busy_res      = main_reg.busy_res;
    assign res.done_res      = main_reg.done_res;
    assign res.rx_byte       = main_reg.rx_byte;
    assign res.nack_received = main_reg.nack_received;
    assign res.cmd_rejected  = main_reg.cmd_rejected;

endmodule

/* src/i2cms_chk.sv */
// ============================================================================
// I2C master byte sequencer - port checker
// Watches the top-level channels for flow and result consistency.
// ============================================================================
module i2cms_chk
    import i2cms_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic cmd_ready,
    input logic res_valid,
    input logic res_ready,
    input logic res_busy,
    input logic res_done,
    input logic res_rejected
);

    // a stalled result stays offered
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result withdrawn while stalled");

    // cmd closes only with a result waiting
    a_cmd_close: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd_ready |-> res_valid)
        else $error("cmd closed with no pending result");

    // a finished command leaves the sequencer idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_done |-> !res_busy)
        else $error("done reported while still busy");

    // a refused command only happens during a running command
    a_reject_busy: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_rejected |-> (res_busy || res_done))
        else $error("command refused while idle");

endmodule

bind i2c_master_byte_sequencer i2cms_chk u_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd_ready    (cmd.ready),
    .res_valid    (res.valid),
    .res_ready    (res.ready),
    .res_busy     (res.busy_res),
    .res_done     (res.done_res),
    .res_rejected (res.cmd_rejected)
);

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ============================================================================
// I2C master byte sequencer - self-checking testbench
// Drives tick transfers carrying start, stop, write-byte and read-byte
// commands with random SDA samples, predicts the SCL/SDA levels and status of
// every tick, and checks each result transfer field by field.
// ============================================================================
module tb_top;
    import i2cms_pkg::*;

    // Command codes outside the defined set; the sequencer treats them as
    // plain ticks when idle and rejects them when busy.
    localparam logic [FUNC_W-1:0] FUNC_RSVD5 = 3'd5;
    localparam logic [FUNC_W-1:0] FUNC_RSVD6 = 3'd6;
    localparam logic [FUNC_W-1:0] FUNC_RSVD7 = 3'd7;

    localparam logic [BITS_W-1:0] BITS_PER_BYTE = 4'd8;
    localparam logic [TICKS_W-1:0] PHASE_TICKS_MAX = 16'hFFFF;

    // Bus phases of the sequencer, one per line change.
    typedef enum logic [4:0] {
        SEQ_IDLE,
        SEQ_S_REL, SEQ_S_SCLH, SEQ_S_SDAL, SEQ_S_SCLL,
        SEQ_P_SDAL, SEQ_P_SCLH, SEQ_P_REL,
        SEQ_W_BIT, SEQ_W_HIGH, SEQ_W_GAP, SEQ_W_ACKH, SEQ_W_ACKL,
        SEQ_R_HIGH, SEQ_R_LOW, SEQ_R_ACKD, SEQ_R_ACKH, SEQ_R_ACKL
    } seq_step_t;

    typedef struct {
        i2cms_item_t tick;
        bit          quiet;    // no source gap after this transfer
    } pending_tick_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_we;
    logic [TICKS_W-1:0] cfg_wdata;
    logic               hold_off = 1'b0;

    i2cms_cmd_if cmd_ch();
    i2cms_res_if res_ch();

    i2c_master_byte_sequencer DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd_ch),
        .res       (res_ch)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // Bus predictor state; mirrors the sequencer from reset onwards
    // ------------------------------------------------------------------------
    seq_step_t          pr_step  = SEQ_IDLE;
    logic [BITS_W-1:0]  pr_bits  = '0;
    logic [BYTE_W-1:0]  pr_shift = '0;
    logic [TICKS_W-1:0] pr_count = '0;
    logic               pr_ack   = 1'b0;
    logic               pr_scl   = 1'b1;
    logic               pr_sda   = 1'b1;
    logic               pr_nack  = 1'b0;
    logic [BYTE_W-1:0]  pr_rx    = '0;
    logic [TICKS_W-1:0] pr_len   = PHASE_TICKS_RESET;

    pending_tick_t pending_ticks[$];
    i2cms_res_t    bus_result_q[$];

    int unsigned ticks_sent   = 0;
    int unsigned results_seen = 0;
    int unsigned mismatches   = 0;
    int unsigned src_wait     = 0;
    int unsigned snk_wait     = 0;
    bit          cur_quiet    = 1'b0;
    bit          snk_quiet    = 1'b0;

    // Stimulus generator knobs
    int unsigned gen_len       = 32'(PHASE_TICKS_RESET);
    int unsigned gen_count     = 0;
    int unsigned gen_noise_pct = 0;
    bit          gen_quiet     = 1'b0;

    // Load a new phase: set the lines and restart the phase timer.
    function automatic void enter_phase(input seq_step_t nxt, input logic scl,
                                        input logic sda);
        pr_step  = nxt;
        pr_scl   = scl;
        pr_sda   = sda;
        pr_count = (pr_len == '0) ? TICKS_W'(1) : pr_len;
    endfunction

    // Close the running phase; returns 1 when the command has finished.
    function automatic logic end_phase(input logic sda_smp);
        logic finished;
        finished = 1'b0;
        case (pr_step)
            SEQ_S_REL:  enter_phase(SEQ_S_SCLH, 1'b1, pr_sda);
            SEQ_S_SCLH: enter_phase(SEQ_S_SDAL, pr_scl, 1'b0);
            SEQ_S_SDAL: enter_phase(SEQ_S_SCLL, 1'b0, pr_sda);
            SEQ_P_SDAL: enter_phase(SEQ_P_SCLH, 1'b1, pr_sda);
            SEQ_P_SCLH: enter_phase(SEQ_P_REL, pr_scl, 1'b1);
            SEQ_W_BIT:  enter_phase(SEQ_W_HIGH, 1'b1, pr_sda);
            SEQ_W_HIGH:
            begin
                // advance to the next data bit, or to the gap before the ACK slot
                pr_bits  = pr_bits + 1'b1;
                pr_shift = pr_shift << 1;
                if (pr_bits >= BITS_PER_BYTE)
                    enter_phase(SEQ_W_GAP, 1'b0, pr_sda);
                else
                    enter_phase(SEQ_W_BIT, 1'b0, pr_shift[BYTE_W-1]);
            end
            SEQ_W_GAP:  enter_phase(SEQ_W_ACKH, 1'b1, 1'b1);
            SEQ_W_ACKH:
            begin
                // a released (high) line at the ACK slot means NACK
                pr_nack = sda_smp;
                enter_phase(SEQ_W_ACKL, 1'b0, pr_sda);
            end
            SEQ_R_HIGH:
            begin
                pr_shift = {pr_shift[BYTE_W-2:0], sda_smp};
                pr_bits  = pr_bits + 1'b1;
                enter_phase(SEQ_R_LOW, 1'b0, pr_sda);
            end
            SEQ_R_LOW:
            begin
                if (pr_bits >= BITS_PER_BYTE)
                    enter_phase(SEQ_R_ACKD, pr_scl, pr_ack);
                else
                    enter_phase(SEQ_R_HIGH, 1'b1, pr_sda);
            end
            SEQ_R_ACKD: enter_phase(SEQ_R_ACKH, 1'b1, pr_sda);
            SEQ_R_ACKH: enter_phase(SEQ_R_ACKL, 1'b0, pr_sda);
            SEQ_R_ACKL:
            begin
                pr_rx    = pr_shift;
                pr_step  = SEQ_IDLE;
                finished = 1'b1;
            end
            default:
            begin
                // last phase of start, stop and write
                pr_step  = SEQ_IDLE;
                finished = 1'b1;
            end
        endcase
        return finished;
    endfunction

    // Work out the line levels and status that one tick leaves behind.
    function automatic i2cms_res_t advance_bus(input i2cms_item_t t);
        i2cms_res_t r;
        logic       finished;
        logic       refused;
        finished = 1'b0;
        refused  = 1'b0;
        if (pr_step != SEQ_IDLE)
        begin
            // any command while busy is dropped and flagged, the finishing tick too
            refused  = (t.func != FUNC_TICK);
            pr_count = pr_count - 1'b1;
            if (pr_count == '0)
                finished = end_phase(t.sda_in);
        end
        else
        begin
            case (t.func)
                FUNC_START:
                begin
                    pr_bits = '0;
                    enter_phase(SEQ_S_REL, pr_scl, 1'b1);
                end
                FUNC_STOP:
                begin
                    pr_bits = '0;
                    enter_phase(SEQ_P_SDAL, pr_scl, 1'b0);
                end
                FUNC_WRITE:
                begin
                    pr_bits  = '0;
                    pr_shift = t.tx_byte;
                    enter_phase(SEQ_W_BIT, 1'b0, t.tx_byte[BYTE_W-1]);
                end
                FUNC_READ:
                begin
                    pr_bits  = '0;
                    pr_shift = '0;
                    pr_ack   = t.nack_to_send;
                    enter_phase(SEQ_R_HIGH, 1'b1, 1'b1);
                end
                default:
                    ; // plain tick or unknown code: nothing happens
            endcase
        end
        r.scl_level     = pr_scl;
        r.sda_release   = pr_sda;
        r.busy_res      = (pr_step != SEQ_IDLE);
        r.done_res      = finished;
        r.rx_byte       = pr_rx;
        r.nack_received = pr_nack;
        r.cmd_rejected  = refused;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        // keep the log readable when the block is badly broken
        if (mismatches < 100)
            $display("mismatch at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input int unsigned got,
                               input int unsigned want);
        if (got != want)
            report_mismatch($sformatf("result %0d %s got 0x%0h, predicted 0x%0h",
                                      results_seen, name, got, want));
    endtask

    // ------------------------------------------------------------------------
    // Source driver: offer pending ticks, hold each until it is taken
    // ------------------------------------------------------------------------
    pending_tick_t offered;
    i2cms_item_t   taken;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_ch.valid        <= 1'b0;
            cmd_ch.func         <= FUNC_TICK;
            cmd_ch.tx_byte      <= '0;
            cmd_ch.nack_to_send <= 1'b0;
            cmd_ch.sda_in       <= 1'b1;
            src_wait = 0;
        end
        else
        begin
            if (cfg_we)
                pr_len = cfg_wdata;
            if (cmd_ch.valid && cmd_ch.ready)
            begin
                // predict on the transfer itself, with the values that were taken
                taken.func         = cmd_ch.func;
                taken.tx_byte      = cmd_ch.tx_byte;
                taken.nack_to_send = cmd_ch.nack_to_send;
                taken.sda_in       = cmd_ch.sda_in;
                bus_result_q.push_back(advance_bus(taken));
                ticks_sent++;
                src_wait = cur_quiet ? 0 : $urandom_range(0, 4);
            end
            // hold an offered tick until the block takes it
            if (!(cmd_ch.valid && !cmd_ch.ready))
            begin
                if (src_wait > 0)
                begin
                    src_wait--;
                    cmd_ch.valid <= 1'b0;
                end
                else if (pending_ticks.size() > 0)
                begin
                    offered = pending_ticks.pop_front();
                    cmd_ch.func         <= offered.tick.func;
                    cmd_ch.tx_byte      <= offered.tick.tx_byte;
                    cmd_ch.nack_to_send <= offered.tick.nack_to_send;
                    cmd_ch.sda_in       <= offered.tick.sda_in;
                    cmd_ch.valid        <= 1'b1;
                    cur_quiet = offered.quiet;
                end
                else
                    cmd_ch.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor: stall at random, compare each transfer with the oldest
    // prediction
    // ------------------------------------------------------------------------
    i2cms_res_t predicted;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
            snk_wait = 0;
        end
        else
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                if (bus_result_q.size() == 0)
                    report_mismatch("result transfer with no tick outstanding");
                else
                begin
                    predicted = bus_result_q.pop_front();
                    check_field("scl_level", 32'(res_ch.scl_level),
                                32'(predicted.scl_level));
                    check_field("sda_release", 32'(res_ch.sda_release),
                                32'(predicted.sda_release));
                    check_field("busy_res", 32'(res_ch.busy_res),
                                32'(predicted.busy_res));
                    check_field("done_res", 32'(res_ch.done_res),
                                32'(predicted.done_res));
                    check_field("rx_byte", 32'(res_ch.rx_byte),
                                32'(predicted.rx_byte));
                    check_field("nack_received", 32'(res_ch.nack_received),
                                32'(predicted.nack_received));
                    check_field("cmd_rejected", 32'(res_ch.cmd_rejected),
                                32'(predicted.cmd_rejected));
                end
                results_seen++;
                snk_wait = snk_quiet ? 0 : $urandom_range(0, 4);
            end
            if (hold_off)
                res_ch.ready <= 1'b0;
            else if (snk_wait > 0)
            begin
                snk_wait--;
                res_ch.ready <= 1'b0;
            end
            else
                res_ch.ready <= 1'b1;
        end
    end

    // Back-pressure: drop ready for a long stretch while ticks keep coming, so
    // the result buffer fills and the block closes its input.
    initial
    begin
        int unsigned mark;
        for (mark = 700; mark <= 1500; mark += 800)
        begin
            while (ticks_sent < mark)
                @(negedge clk);
            @(posedge clk);
            hold_off <= 1'b1;
            repeat (80) @(posedge clk);
            hold_off <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic push_tick(input logic [FUNC_W-1:0] f, input logic [BYTE_W-1:0] tx,
                             input logic nack);
        pending_tick_t e;
        e.tick.func         = f;
        e.tick.tx_byte      = tx;
        e.tick.nack_to_send = nack;
        e.tick.sda_in       = 1'($urandom_range(0, 1));
        e.quiet             = gen_quiet;
        pending_ticks.push_back(e);
        gen_count++;
    endtask

    // Plain ticks with random content; a few carry a command that lands while busy.
    task automatic push_pad(input int unsigned n);
        logic [FUNC_W-1:0] f;
        repeat (n)
        begin
            f = FUNC_TICK;
            if ($urandom_range(0, 99) < gen_noise_pct)
                f = FUNC_W'($urandom_range(FUNC_START, FUNC_RSVD7));
            push_tick(f, BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end
    endtask

    function automatic int phases_of(input logic [FUNC_W-1:0] f);
        case (f)
            FUNC_START: return 4;
            FUNC_STOP:  return 3;
            FUNC_WRITE: return 2 * BITS_PER_BYTE + 3;
            FUNC_READ:  return 2 * BITS_PER_BYTE + 3;
            default:    return 0;
        endcase
    endfunction

    // Issue a command and pad it out to its length; a negative slack lets the
    // next command arrive while this one is still running.
    task automatic push_cmd(input logic [FUNC_W-1:0] f, input logic [BYTE_W-1:0] tx,
                            input logic nack, input int slack);
        int pad;
        push_tick(f, tx, nack);
        pad = phases_of(f) * gen_len + slack;
        if (pad > 0)
            push_pad(pad);
    endtask

    function automatic int random_slack();
        if ($urandom_range(0, 99) < 85)
            return int'($urandom_range(0, 2));
        return -int'($urandom_range(1, 6));
    endfunction

    // Wait until every tick is taken and checked.
    task automatic drain();
        @(negedge clk);
        while (pending_ticks.size() != 0 || cmd_ch.valid || bus_result_q.size() != 0)
            @(negedge clk);
    endtask

    // Wait until every tick is taken and checked and the sequencer is idle;
    // feed plain ticks while a command is still running.
    task automatic settle();
        bit running;
        running = 1'b1;
        while (running)
        begin
            drain();
            if (pr_step == SEQ_IDLE)
                running = 1'b0;
            else
                push_pad(32'(pr_count));
        end
        repeat (3) @(posedge clk);
    endtask

    task automatic write_phase_len(input logic [TICKS_W-1:0] v);
        settle();
        cfg_wdata <= v;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we    <= 1'b0;
        gen_len = (v == '0) ? 1 : 32'(v);
        @(negedge clk);
    endtask

    // Mostly well-formed transactions with random content, the rest noise.
    task automatic random_traffic(input int unsigned budget);
        int unsigned stop_at;
        stop_at = gen_count + budget;
        while (gen_count < stop_at)
        begin
            gen_quiet = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 99) < 80)
            begin
                push_cmd(FUNC_START, BYTE_W'($urandom_range(0, 255)),
                         1'($urandom_range(0, 1)), random_slack());
                repeat ($urandom_range(1, 3))
                begin
                    if ($urandom_range(0, 1))
                        push_cmd(FUNC_WRITE, BYTE_W'($urandom_range(0, 255)),
                                 1'($urandom_range(0, 1)), random_slack());
                    else
                        push_cmd(FUNC_READ, BYTE_W'($urandom_range(0, 255)),
                                 1'($urandom_range(0, 1)), random_slack());
                end
                push_cmd(FUNC_STOP, BYTE_W'($urandom_range(0, 255)),
                         1'($urandom_range(0, 1)), random_slack());
            end
            else
            begin
                repeat ($urandom_range(1, 6))
                    push_tick(FUNC_W'($urandom_range(FUNC_TICK, FUNC_RSVD7)),
                              BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int i;
        int unsigned lens[6];
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset phase length: unknown codes while idle are plain ticks, then a
        // full start and stop at 50 ticks per phase.
        push_tick(FUNC_RSVD5, 8'h00, 1'b0);
        push_tick(FUNC_RSVD6, 8'hFF, 1'b1);
        push_tick(FUNC_RSVD7, 8'h00, 1'b0);
        push_tick(FUNC_TICK, 8'hFF, 1'b1);
        push_cmd(FUNC_START, 8'h00, 1'b0, 0);
        push_cmd(FUNC_STOP, 8'h00, 1'b0, 0);

        // Shortest phases: every command, byte extremes, ACK and NACK, commands
        // in mid-command and on the finishing tick.
        write_phase_len(16'd1);
        push_cmd(FUNC_START, 8'h00, 1'b0, 0);
        push_cmd(FUNC_WRITE, 8'hFF, 1'b0, 0);
        push_cmd(FUNC_WRITE, 8'h00, 1'b1, 0);
        push_cmd(FUNC_READ, 8'h00, 1'b0, 0);
        push_cmd(FUNC_READ, 8'hFF, 1'b1, 0);
        push_cmd(FUNC_WRITE, 8'hA5, 1'b0, -1);
        push_tick(FUNC_READ, 8'h00, 1'b1);          // lands on the finishing tick
        push_tick(FUNC_TICK, 8'h00, 1'b0);
        push_cmd(FUNC_WRITE, 8'h5A, 1'b1, -12);
        push_tick(FUNC_STOP, 8'h00, 1'b0);          // rejected mid-byte
        push_tick(FUNC_RSVD7, 8'h00, 1'b0);         // unknown code, still rejected
        push_pad(10);
        push_tick(FUNC_RSVD5, 8'h00, 1'b0);
        push_cmd(FUNC_STOP, 8'h00, 1'b0, 0);

        // Random traffic across short phase lengths, zero among them
        lens = '{0, 1, 2, 3, 1, 6};
        for (i = 0; i < 6; i++)
        begin
            write_phase_len(TICKS_W'(lens[i]));
            snk_quiet = (i % 3 == 2);
            gen_noise_pct = 4;
            random_traffic(130);
        end

        // Longest phases: a stop entered and held in its first phase, both
        // sides streaming
        write_phase_len(PHASE_TICKS_MAX);
        gen_noise_pct = 0;
        gen_quiet = 1'b1;
        snk_quiet = 1'b1;
        push_tick(FUNC_STOP, 8'h00, 1'b0);
        push_pad(200);
        drain();

        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("[i2c_master_byte_sequencer] OK");
        else
            $display("[i2c_master_byte_sequencer] ERROR");
        $finish;
    end

    // Watchdog: 2 ms, well beyond the slowest correct run
    initial
    begin
        #2_000_000;
        $display("[i2c_master_byte_sequencer] ERROR");
        $finish;
    end

endmodule

/* files.f */
src/i2cms_pkg.sv
src/i2cms_if.sv
src/i2cms_core.sv
src/i2c_master_byte_sequencer.sv
src/i2cms_chk.sv
tb/tb_top.sv
